// File: src/tlpt_pkg.sv
// ----------------------------------------------------------------------------
// tlpt_pkg
// Shared sizes, result codes and controller/datapath interface types of the
// two-level page table.
// ----------------------------------------------------------------------------
package tlpt_pkg;

  localparam int TABLE_SLOTS = 4;

  localparam int VA_W       = 32;
  localparam int FLAG_W     = 12;
  localparam int IDX_W      = 10;
  localparam int DIR_DEPTH  = 1 << IDX_W;
  localparam int SLOT_W     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int NF_W       = $clog2(TABLE_SLOTS + 1);
  localparam int DIR_W      = SLOT_W + 1;
  localparam int TBL_AW     = SLOT_W + IDX_W;
  localparam int TBL_DEPTH  = TABLE_SLOTS * DIR_DEPTH;

  localparam logic [VA_W-1:0] FRAME_MASK  = 32'hFFFF_F000;
  localparam logic [VA_W-1:0] OFFSET_MASK = 32'h0000_0FFF;

  localparam logic [1:0] RES_ZERO  = 2'd0;
  localparam logic [1:0] RES_FULL  = 2'd1;
  localparam logic [1:0] RES_FAULT = 2'd2;
  localparam logic [1:0] RES_WALK  = 2'd3;

  typedef struct packed {
    logic       clr_step;
    logic       capture;
    logic       dir_alloc;
    logic       tbl_write;
    logic       tbl_read;
    logic       load_res;
    logic [1:0] res_sel;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic op_translate;
    logic dir_present;
    logic slots_exhausted;
    logic out_free;
  } sts_t;

endpackage

// File: src/tlpt_ctrl.sv
// ----------------------------------------------------------------------------
// tlpt_ctrl
// Sequencer: clearing pass after reset, then one item at a time through
// directory lookup and table walk.
// ----------------------------------------------------------------------------
module tlpt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tlpt_pkg::sts_t sts_i,
  output tlpt_pkg::cmd_t cmd_o
);
  import tlpt_pkg::*;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_LOOKUP = 2'd2;
  localparam logic [1:0] ST_WALK   = 2'd3;

  logic [1:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (sts_i.op_translate) begin
          if (sts_i.dir_present) begin
            cmd_o.tbl_read = 1'b1;
            state_d        = ST_WALK;
          end else if (sts_i.out_free) begin
            cmd_o.load_res = 1'b1;
            cmd_o.res_sel  = RES_FAULT;
            state_d        = ST_IDLE;
          end
        end else if (sts_i.out_free) begin
          cmd_o.load_res = 1'b1;
          state_d        = ST_IDLE;
          if (!sts_i.dir_present && sts_i.slots_exhausted) begin
            cmd_o.res_sel = RES_FULL;
          end else begin
            cmd_o.res_sel   = RES_ZERO;
            cmd_o.tbl_write = 1'b1;
            cmd_o.dir_alloc = !sts_i.dir_present;
          end
        end
      end
      ST_WALK: begin
        if (sts_i.out_free) begin
          cmd_o.load_res = 1'b1;
          cmd_o.res_sel  = RES_WALK;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

// File: src/tlpt_datapath.sv
// ----------------------------------------------------------------------------
// tlpt_datapath
// Directory and table memories, bump allocator, item capture and result
// register.
// ----------------------------------------------------------------------------
module tlpt_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_operation_i,
  input  logic [tlpt_pkg::VA_W-1:0]    in_virtual_address_i,
  input  logic [tlpt_pkg::VA_W-1:0]    in_physical_address_i,
  input  logic [tlpt_pkg::FLAG_W-1:0]  in_entry_flags_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tlpt_pkg::VA_W-1:0]    out_translated_address_o,
  output logic                         out_fault_o,
  output logic                         out_table_full_o,
  input  tlpt_pkg::cmd_t               cmd_i,
  output tlpt_pkg::sts_t               sts_o
);
  import tlpt_pkg::*;

  logic [DIR_W-1:0]  dir_mem [DIR_DEPTH];
  logic [VA_W-1:0]   tbl_mem [TBL_DEPTH];

  logic [DIR_W-1:0]  dir_rd_q;
  logic [VA_W-1:0]   tbl_rd_q;

  logic              op_q;
  logic [VA_W-1:0]   va_q;
  logic [VA_W-1:0]   pa_q;
  logic [FLAG_W-1:0] fl_q;

  logic [TBL_AW-1:0] clr_cnt_q, clr_cnt_d;
  logic [NF_W-1:0]   next_free_q, next_free_d;

  logic              out_valid_q, out_valid_d;
  logic [VA_W-1:0]   res_addr_q, res_addr_d;
  logic              res_fault_q, res_fault_d;
  logic              res_full_q, res_full_d;

  logic [SLOT_W-1:0] slot;
  logic [TBL_AW-1:0] tbl_addr;
  logic [VA_W-1:0]   tbl_wdata;

  assign slot      = cmd_i.dir_alloc ? next_free_q[SLOT_W-1:0] : dir_rd_q[SLOT_W-1:0];
  assign tbl_addr  = {slot, va_q[2*IDX_W+FLAG_W-1-IDX_W -: IDX_W]};
  assign tbl_wdata = (pa_q & FRAME_MASK) | {{(VA_W-FLAG_W){1'b0}}, fl_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      dir_mem[clr_cnt_q[IDX_W-1:0]] <= '0;
    end else if (cmd_i.dir_alloc) begin
      dir_mem[va_q[VA_W-1 -: IDX_W]] <= {1'b1, next_free_q[SLOT_W-1:0]};
    end
    if (cmd_i.capture) begin
      dir_rd_q <= dir_mem[in_virtual_address_i[VA_W-1 -: IDX_W]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      tbl_mem[clr_cnt_q] <= '0;
    end else if (cmd_i.tbl_write) begin
      tbl_mem[tbl_addr] <= tbl_wdata;
    end
    if (cmd_i.tbl_read) begin
      tbl_rd_q <= tbl_mem[tbl_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q <= in_operation_i;
      va_q <= in_virtual_address_i;
      pa_q <= in_physical_address_i;
      fl_q <= in_entry_flags_i;
    end
  end

  always_comb begin
    clr_cnt_d   = cmd_i.clr_step ? clr_cnt_q + TBL_AW'(1) : clr_cnt_q;
    next_free_d = cmd_i.dir_alloc ? next_free_q + NF_W'(1) : next_free_q;
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    res_addr_d  = res_addr_q;
    res_fault_d = res_fault_q;
    res_full_d  = res_full_q;
    if (cmd_i.load_res) begin
      out_valid_d = 1'b1;
      res_addr_d  = '0;
      res_fault_d = 1'b0;
      res_full_d  = 1'b0;
      case (cmd_i.res_sel)
        RES_ZERO:  res_addr_d = '0;
        RES_FULL:  res_full_d = 1'b1;
        RES_FAULT: res_fault_d = 1'b1;
        RES_WALK: begin
          if (tbl_rd_q[0]) begin
            res_addr_d = (tbl_rd_q & FRAME_MASK) | (va_q & OFFSET_MASK);
          end else begin
            res_fault_d = 1'b1;
          end
        end
        default: res_addr_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      next_free_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      clr_cnt_q   <= clr_cnt_d;
      next_free_q <= next_free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_addr_q  <= res_addr_d;
    res_fault_q <= res_fault_d;
    res_full_q  <= res_full_d;
  end

  assign sts_o.clr_last        = (clr_cnt_q == TBL_AW'(TBL_DEPTH - 1));
  assign sts_o.op_translate    = op_q;
  assign sts_o.dir_present     = dir_rd_q[DIR_W-1];
  assign sts_o.slots_exhausted = (next_free_q == NF_W'(TABLE_SLOTS));
  assign sts_o.out_free        = !out_valid_q || !out_stall_i;

  assign out_valid_o              = out_valid_q;
  assign out_translated_address_o = res_addr_q;
  assign out_fault_o              = res_fault_q;
  assign out_table_full_o         = res_full_q;

endmodule

// File: src/two_level_page_table_map_translate.sv
// A map item or a directory fault loads its result in the lookup state; a
// full table walk reads the table there and loads its result in the walk
// state. Each load waits while a stalled result holds the output. A new item
// is taken only in idle, once the last result is loaded; the dependent
// directory and table memory reads are each registered. Reset: a clearing
// pass zeroes both memories; no item is accepted until it ends.
// ----------------------------------------------------------------------------
// two_level_page_table_map_translate
// Two-level page table with map and translate items, split into a sequencer
// and a memory datapath.
// ----------------------------------------------------------------------------
module two_level_page_table_map_translate (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         in_operation_i,
  input  logic [tlpt_pkg::VA_W-1:0]    in_virtual_address_i,
  input  logic [tlpt_pkg::VA_W-1:0]    in_physical_address_i,
  input  logic [tlpt_pkg::FLAG_W-1:0]  in_entry_flags_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tlpt_pkg::VA_W-1:0]    out_translated_address_o,
  output logic                         out_fault_o,
  output logic                         out_table_full_o
);
  import tlpt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tlpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tlpt_datapath u_datapath (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .in_operation_i           (in_operation_i),
    .in_virtual_address_i     (in_virtual_address_i),
    .in_physical_address_i    (in_physical_address_i),
    .in_entry_flags_i         (in_entry_flags_i),
    .out_valid_o              (out_valid_o),
    .out_stall_i              (out_stall_i),
    .out_translated_address_o (out_translated_address_o),
    .out_fault_o              (out_fault_o),
    .out_table_full_o         (out_table_full_o),
    .cmd_i                    (cmd),
    .sts_o                    (sts)
  );

`ifndef NO_ASSERTIONS
  a_one_item_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("item accepted while another is in flight");

  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_step |-> (!out_valid_o && in_stall_o))
    else $error("activity during clearing pass");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_fault_o && out_table_full_o))
    else $error("fault and table_full together");

  a_error_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_fault_o || out_table_full_o)) |-> (out_translated_address_o == '0))
    else $error("nonzero address on error result");
`endif

endmodule
